// ===== rtl/line_follow_steering_fsm_defines.svh =====
// Assertion macros shared by the steering block.
`ifndef LINE_FOLLOW_STEERING_FSM_DEFINES_SVH
`define LINE_FOLLOW_STEERING_FSM_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LFS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lfs_pkg.sv =====
package lfs_pkg;

  // register reset values
  localparam logic [6:0] FULL_DUTY_RST    = 7'd40;
  localparam logic [6:0] HALF_DUTY_RST    = 7'd32;
  localparam logic [9:0] TURN_HOLD_RST    = 10'd500;

  localparam logic [1:0] REG_FULL_DUTY    = 2'd0;
  localparam logic [1:0] REG_HALF_DUTY    = 2'd1;
  localparam logic [1:0] REG_TURN_HOLD    = 2'd2;

  // 8-bit padded dividend, two quotient bits per cycle
  localparam int DIV_STEPS = 4;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef struct packed {
    logic capture;   // load sample and divider operands
    logic step;      // one divider iteration
    logic finish;    // write result register, advance steering state
  } lfs_cmd_t;

  typedef struct packed {
    logic inactive;  // captured speed divisor is zero
  } lfs_stat_t;

endpackage

// ===== rtl/lfs_ctrl.sv =====
`include "line_follow_steering_fsm_defines.svh"

module lfs_ctrl import lfs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  lfs_stat_t stat,
  output lfs_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  assign in_stall   = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && in_valid;
  assign cmd.step    = (state == S_DIV) && !stat.inactive;
  assign cmd.finish  = (state == S_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // idle items skip the divider
          if (stat.inactive || cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
          cnt <= cnt + 1'b1;
        end
        S_FIN: begin
          if (cmd.finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LFS_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid, "finished item not presented")
  `LFS_ASSERT_IMPL(a_no_overwrite, cmd.finish, !out_valid || !out_stall, "waiting item overwritten")
  `LFS_ASSERT_IMPL(a_rose_from_finish, $rose(out_valid), $past(cmd.finish), "result without item")
  `LFS_ASSERT_IMPL(a_busy_stalls, cmd.step, in_stall, "input taken while dividing")

endmodule

// ===== rtl/lfs_dp.sv =====
module lfs_dp import lfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lfs_cmd_t          cmd,
  output lfs_stat_t         stat,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data,
  input  logic signed [9:0] line_position,
  input  logic              line_lost,
  input  logic [2:0]        speed_divisor,
  output logic              acted,
  output logic [3:0]        state_code,
  output logic signed [7:0] left_drive,
  output logic signed [7:0] right_drive,
  output logic [3:0]        lamp_bits,
  output logic [9:0]        hold_ms
);

  typedef enum logic [3:0] {
    ST_PIVOT_L  = 4'd0,  ST_ROTATE_L = 4'd1,  ST_FWD_L  = 4'd2,  ST_ADJ_L = 4'd3,
    ST_CENTER   = 4'd4,  ST_ADJ_R    = 4'd5,  ST_FWD_R  = 4'd6,  ST_ROTATE_R = 4'd7,
    ST_PIVOT_R  = 4'd8,  ST_HARD_R   = 4'd9,  ST_LC     = 4'd10, ST_HARD_L = 4'd11,
    ST_RC       = 4'd12, ST_LOST     = 4'd13
  } steer_t;

  typedef enum logic [2:0] {OP_ZERO, OP_FULL, OP_HALF, OP_HALF_QTR, OP_HALF_HLF} opnd_t;
  typedef enum logic [1:0] {HOLD_NONE, HOLD_ADJ, HOLD_TURN} hold_t;

  localparam logic signed [9:0] P_M334 = -10'sd334;
  localparam logic signed [9:0] P_M239 = -10'sd239;
  localparam logic signed [9:0] P_M238 = -10'sd238;
  localparam logic signed [9:0] P_M143 = -10'sd143;
  localparam logic signed [9:0] P_M142 = -10'sd142;
  localparam logic signed [9:0] P_M48  = -10'sd48;
  localparam logic signed [9:0] P_M47  = -10'sd47;
  localparam logic signed [9:0] P_48   = 10'sd48;
  localparam logic signed [9:0] P_49   = 10'sd49;
  localparam logic signed [9:0] P_142  = 10'sd142;
  localparam logic signed [9:0] P_143  = 10'sd143;
  localparam logic signed [9:0] P_238  = 10'sd238;
  localparam logic signed [9:0] P_239  = 10'sd239;
  localparam logic signed [9:0] P_334  = 10'sd334;
  localparam logic [7:0]        CROSS_LIMIT = 8'd3;
  localparam logic [9:0]        ADJUST_HOLD = 10'd50;

  // config
  logic [6:0] full_duty;
  logic [6:0] half_duty;
  logic [9:0] turn_hold_ms;

  // steering state
  steer_t     steer_state;
  logic [7:0] crossing_count;
  logic [3:0] lamp_latch;

  // captured sample and divider
  logic signed [9:0] pos;
  logic              lost;
  logic [2:0]        div;
  logic [7:0]        num_a, num_b;
  logic [2:0]        rem_a, rem_b;

  // per-state drive pattern
  opnd_t      sel_a, sel_b;
  logic       neg_a, neg_b;
  logic [3:0] lamps;
  hold_t      hold_sel;

  steer_t     steer_next;
  logic [7:0] crossing_next;
  logic [7:0] drive_a, drive_b;
  logic [9:0] hold_val;
  logic [10:0] a1, a2, b1, b2;

  function automatic logic [6:0] opnd_val(opnd_t s, logic [6:0] fd, logic [6:0] hd);
    case (s)
      OP_FULL:     return fd;
      OP_HALF:     return hd;
      OP_HALF_QTR: return hd >> 2;
      OP_HALF_HLF: return hd >> 1;
      default:     return 7'd0;
    endcase
  endfunction

  // one restoring step: returns {shifted numerator/quotient, remainder}
  function automatic logic [10:0] div_step(logic [7:0] n, logic [2:0] r, logic [2:0] d);
    logic [3:0] r4;
    r4 = {r, n[7]};
    if (r4 >= {1'b0, d}) begin
      return {n[6:0], 1'b1, 3'(r4 - {1'b0, d})};
    end else begin
      return {n[6:0], 1'b0, r4[2:0]};
    end
  endfunction

  function automatic steer_t band(logic signed [9:0] p, logic l, steer_t cur);
    if (l)                          return ST_LOST;
    else if (p >= P_M334 && p <= P_M239) return ST_PIVOT_L;
    else if (p >= P_M238 && p <= P_M143) return ST_ROTATE_L;
    else if (p >= P_M142 && p <= P_M48)  return ST_FWD_L;
    else if (p >= P_M47 && p <= P_48)    return ST_CENTER;
    else if (p >= P_49 && p <= P_142)    return ST_FWD_R;
    else if (p >= P_143 && p <= P_238)   return ST_ROTATE_R;
    else if (p >= P_239 && p <= P_334)   return ST_PIVOT_R;
    else                                 return cur;
  endfunction

  assign stat.inactive = (div == 3'd0);

  always_comb begin
    sel_a    = OP_ZERO;
    sel_b    = OP_ZERO;
    neg_a    = 1'b0;
    neg_b    = 1'b0;
    lamps    = lamp_latch;
    hold_sel = HOLD_NONE;
    case (steer_state)
      ST_PIVOT_L: begin
        lamps = 4'h1; sel_a = OP_HALF; neg_a = 1'b1; sel_b = OP_FULL;
      end
      ST_ROTATE_L: begin
        lamps = 4'h1; sel_a = OP_HALF_QTR; neg_a = 1'b1; sel_b = OP_FULL;
      end
      ST_FWD_L: begin
        lamps = 4'h1; sel_a = OP_HALF; sel_b = OP_FULL;
      end
      // its own pulse is overwritten by the centre drive
      ST_ADJ_L: begin
        lamps = 4'h3; sel_a = OP_FULL; sel_b = OP_FULL; hold_sel = HOLD_ADJ;
      end
      ST_CENTER: begin
        lamps = 4'h3; sel_a = OP_FULL; sel_b = OP_FULL;
      end
      ST_ADJ_R: begin
        lamps = 4'h1; sel_a = OP_HALF; sel_b = OP_FULL; neg_b = 1'b1;
        hold_sel = HOLD_ADJ;
      end
      ST_FWD_R: begin
        lamps = 4'h2; sel_a = OP_FULL; sel_b = OP_HALF;
      end
      ST_ROTATE_R: begin
        lamps = 4'h2; sel_a = OP_FULL; sel_b = OP_HALF_HLF;
      end
      ST_PIVOT_R: begin
        lamps = 4'h2; sel_a = OP_FULL; sel_b = OP_HALF; neg_b = 1'b1;
      end
      ST_HARD_R: begin
        lamps = 4'h2; sel_a = OP_FULL; hold_sel = HOLD_TURN;
      end
      ST_LC, ST_RC: begin
        lamps = 4'h3; sel_a = OP_FULL; sel_b = OP_FULL; hold_sel = HOLD_TURN;
      end
      ST_HARD_L: begin
        lamps = (lamp_latch & 4'h4) | 4'h1; sel_b = OP_FULL; hold_sel = HOLD_TURN;
      end
      ST_LOST: begin
        lamps = 4'hC; sel_a = OP_HALF; neg_a = 1'b1; sel_b = OP_HALF; neg_b = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (hold_sel)
      HOLD_ADJ:  hold_val = ADJUST_HOLD;
      HOLD_TURN: hold_val = turn_hold_ms;
      default:   hold_val = 10'd0;
    endcase
  end

  // next steering state and crossing counter
  always_comb begin
    crossing_next = crossing_count;
    steer_next    = band(pos, lost, steer_state);
    case (steer_state)
      ST_ROTATE_L: begin
        if (pos >= P_M143 && pos <= P_M48) crossing_next = crossing_count + 8'd1;
        if (pos <= P_M143) crossing_next = 8'd0;
        if (lost) steer_next = ST_HARD_R;
      end
      ST_FWD_L: begin
        if (crossing_count >= CROSS_LIMIT) steer_next = ST_ADJ_R;
      end
      ST_ADJ_L, ST_ADJ_R: crossing_next = 8'd0;
      ST_FWD_R: begin
        if (crossing_count >= CROSS_LIMIT) steer_next = ST_ADJ_L;
      end
      ST_ROTATE_R: begin
        if (pos >= P_48 && pos <= P_143) crossing_next = crossing_count + 8'd1;
        else if (pos >= P_143) crossing_next = 8'd0;
        if (lost) steer_next = ST_HARD_L;
      end
      ST_HARD_R, ST_HARD_L: begin
        if (lost) steer_next = ST_LC;
      end
      ST_LC, ST_RC: begin
        if (lost) steer_next = ST_LOST;
      end
      ST_PIVOT_L, ST_CENTER, ST_PIVOT_R, ST_LOST: ;
      default: steer_next = steer_state;
    endcase
  end

  assign a1 = div_step(num_a, rem_a, div);
  assign a2 = div_step(a1[10:3], a1[2:0], div);
  assign b1 = div_step(num_b, rem_b, div);
  assign b2 = div_step(b1[10:3], b1[2:0], div);

  // quotients never exceed 127, so the top bit is clear
  assign drive_a = neg_a ? (8'd0 - num_a) : num_a;
  assign drive_b = neg_b ? (8'd0 - num_b) : num_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_duty      <= FULL_DUTY_RST;
      half_duty      <= HALF_DUTY_RST;
      turn_hold_ms   <= TURN_HOLD_RST;
      steer_state    <= ST_CENTER;
      crossing_count <= 8'd0;
      lamp_latch     <= 4'd0;
      div            <= 3'd0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FULL_DUTY: full_duty    <= cfg_data[6:0];
          REG_HALF_DUTY: half_duty    <= cfg_data[6:0];
          REG_TURN_HOLD: turn_hold_ms <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        div <= speed_divisor;
      end
      if (cmd.finish && !stat.inactive) begin
        steer_state    <= steer_next;
        crossing_count <= crossing_next;
        lamp_latch     <= lamps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos   <= line_position;
      lost  <= line_lost;
      num_a <= {1'b0, opnd_val(sel_a, full_duty, half_duty)};
      num_b <= {1'b0, opnd_val(sel_b, full_duty, half_duty)};
      rem_a <= 3'd0;
      rem_b <= 3'd0;
    end else if (cmd.step) begin
      num_a <= a2[10:3];
      rem_a <= a2[2:0];
      num_b <= b2[10:3];
      rem_b <= b2[2:0];
    end
    if (cmd.finish) begin
      state_code <= steer_state;
      if (stat.inactive) begin
        acted       <= 1'b0;
        left_drive  <= 8'sd0;
        right_drive <= 8'sd0;
        lamp_bits   <= lamp_latch;
        hold_ms     <= 10'd0;
      end else begin
        acted       <= 1'b1;
        left_drive  <= $signed(drive_a);
        right_drive <= $signed(drive_b);
        lamp_bits   <= lamps;
        hold_ms     <= hold_val;
      end
    end
  end

endmodule

// ===== rtl/line_follow_steering_fsm.sv =====
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------------------
// in       | in_valid/in_stall   | line_position, line_lost, speed_divisor
// out      | out_valid/out_stall | acted, state_code, left/right_drive, lamp_bits, hold_ms
// cfg      | cfg_write           | cfg_index, cfg_data
//
// One item at a time. An active item goes through capture, the divider steps
// (two quotient bits each) and the result load; an idle one skips the divider
// steps. The two-lane divider works on both drive values together.
// Synchronous active-high reset: Center state, counters and lamps clear,
// registers to 40/32/500.
// A new item is taken while a result waits on out_stall; a second one then
// waits in the final step until the output register frees.
module line_follow_steering_fsm import lfs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [9:0] line_position,
  input  logic              line_lost,
  input  logic [2:0]        speed_divisor,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              acted,
  output logic [3:0]        state_code,
  output logic signed [7:0] left_drive,
  output logic signed [7:0] right_drive,
  output logic [3:0]        lamp_bits,
  output logic [9:0]        hold_ms,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [9:0]        cfg_data
);

  lfs_cmd_t  cmd;
  lfs_stat_t stat;

  lfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfs_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .line_position (line_position),
    .line_lost     (line_lost),
    .speed_divisor (speed_divisor),
    .acted         (acted),
    .state_code    (state_code),
    .left_drive    (left_drive),
    .right_drive   (right_drive),
    .lamp_bits     (lamp_bits),
    .hold_ms       (hold_ms)
  );

endmodule
